@@ rtl/pahm_pkg.sv @@
// Shared types, constants and MD5 round helpers for the pointer authentication unit.
package pahm_pkg;

  localparam int unsigned RoundsPerBlk = 64;
  localparam int unsigned NumStages    = 3 * RoundsPerBlk;
  localparam int unsigned AddrW        = 48;
  localparam int unsigned TagW         = 16;
  localparam int unsigned PtrW         = 64;
  localparam int unsigned KeyW         = 128;

  localparam logic [127:0] Md5Iv = 128'h10325476_98badcfe_efcdab89_67452301;
  localparam logic [7:0]   IpadByte = 8'h36;
  localparam logic [7:0]   OpadByte = 8'h5c;
  // Bit lengths of the inner (64 + 6 bytes) and outer (64 + 16 bytes) messages.
  localparam logic [31:0]  InnerBits = 32'd560;
  localparam logic [31:0]  OuterBits = 32'd640;

  localparam logic [0:0] RegKeyLow  = 1'b0;
  localparam logic [0:0] RegKeyHigh = 1'b1;

  localparam logic [31:0] Md5K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned Md5R [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // One pipeline stage: two running chaining values, a 128-bit message source,
  // a saved chaining value and the item's own fields.
  typedef struct packed {
    logic [127:0]      run_a;
    logic [127:0]      run_b;
    logic [KeyW-1:0]   msg;
    logic [127:0]      hsave;
    logic [AddrW-1:0]  addr;
    logic              act;
    logic [TagW-1:0]   gtag;
  } stg_t;

  function automatic int unsigned msg_idx(int unsigned i);
    int unsigned rnd;
    rnd = i >> 4;
    case (rnd)
      0:       return i & 15;
      1:       return (5 * i + 1) & 15;
      2:       return (3 * i + 5) & 15;
      default: return (7 * i) & 15;
    endcase
  endfunction

  function automatic logic [127:0] md5_round(logic [127:0] s, logic [31:0] w,
                                             int unsigned i);
    logic [31:0] a, b, c, d, f, t, r;
    int unsigned sh;
    a = s[31:0];
    b = s[63:32];
    c = s[95:64];
    d = s[127:96];
    case (i >> 4)
      0:       f = (b & c) | (~b & d);
      1:       f = (d & b) | (~d & c);
      2:       f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sh = Md5R[((i >> 4) << 2) | (i & 3)];
    t = a + f + Md5K[i] + w;
    r = (t << sh) | (t >> (32 - sh));
    return {c, b, b + r, d};
  endfunction

  function automatic logic [127:0] md5_ff(logic [127:0] x, logic [127:0] y);
    logic [127:0] s;
    for (int j = 0; j < 4; j++) begin
      s[32*j +: 32] = x[32*j +: 32] + y[32*j +: 32];
    end
    return s;
  endfunction

  // Word j of a key block padded with the given byte.
  function automatic logic [31:0] key_word(logic [KeyW-1:0] k, int unsigned j,
                                           logic [7:0] pad);
    if (j < 4) begin
      return k[32*j +: 32] ^ {4{pad}};
    end
    return {4{pad}};
  endfunction

  // Word j of the inner second block: six address bytes, the pad marker, length.
  function automatic logic [31:0] addr_word(logic [AddrW-1:0] ad, int unsigned j);
    case (j)
      0:       return ad[31:0];
      1:       return {16'h0080, ad[47:32]};
      14:      return InnerBits;
      default: return 32'h0;
    endcase
  endfunction

  // Word j of the outer second block: the inner digest, pad marker, length.
  function automatic logic [31:0] dig_word(logic [127:0] dg, int unsigned j);
    if (j < 4) begin
      return dg[32*j +: 32];
    end
    case (j)
      4:       return 32'h0000_0080;
      14:      return OuterBits;
      default: return 32'h0;
    endcase
  endfunction

endpackage

@@ rtl/pointer_auth_hmac_md5.sv @@
// Pointer authentication unit: HMAC-MD5 tag over a 48-bit address, fully pipelined.
//
// Each input word either signs a plain 48-bit address (tuser = 0) or checks a
// signed pointer (tuser = 1). The tag is the low 16 bits of HMAC-MD5, keyed by
// the 128-bit key in key_low/key_high, over the six address bytes taken
// little-endian. A sign word returns tag in bits 63..48 above the address with
// auth_fail 0; a check word returns the stripped address and sets auth_fail
// when bits 63..48 of the input differ from the recomputed tag. The datapath is
// a 192-stage pipeline, one MD5 round per stage: the first 64 stages run the
// inner and outer key blocks side by side, the next 64 the inner address block
// and the last 64 the outer digest block. A word enters every cycle while the
// pipe advances; its result leaves through the output register. The whole pipe
// advances together whenever the output register is empty or being taken, so
// a stall at the output freezes every stage and loses nothing. The key is
// captured with each word as it enters, so key writes take effect for the next
// word accepted after the write.
module pointer_auth_hmac_md5 (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [63:0] cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // pointer_value [63:0]
  input  logic        s_axis_tuser_i,   // action [0]
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // result_pointer [63:0]
  output logic        m_axis_tuser_o    // auth_fail [0]
);

  localparam int unsigned NStg = pahm_pkg::NumStages;
  localparam int unsigned NRnd = pahm_pkg::RoundsPerBlk;

  logic [63:0] key_low_q, key_high_q;

  pahm_pkg::stg_t stg_q [NStg];
  pahm_pkg::stg_t stg_d [NStg];
  logic [NStg-1:0] vld_q;

  logic        out_vld_q;
  logic [63:0] out_ptr_q;
  logic        out_fail_q;
  logic [63:0] out_ptr_d;
  logic        out_fail_d;
  logic [pahm_pkg::TagW-1:0] tag;
  logic        adv;

  // Pipe advances when the output register is free or drains this cycle.
  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pahm_pkg::RegKeyLow:  key_low_q  <= cfg_wdata_i;
        pahm_pkg::RegKeyHigh: key_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < NStg; k++) begin : g_stage
    localparam int unsigned Ph = k / NRnd;
    localparam int unsigned Ri = k % NRnd;
    localparam int unsigned Gi = pahm_pkg::msg_idx(Ri);
    localparam int unsigned Pk = (k == 0) ? 0 : k - 1;
    pahm_pkg::stg_t inp;

    always_comb begin
      if (k == 0) begin
        inp.run_a = pahm_pkg::Md5Iv;
        inp.run_b = pahm_pkg::Md5Iv;
        inp.msg   = {key_high_q, key_low_q};
        inp.hsave = '0;
        inp.addr  = s_axis_tdata_i[pahm_pkg::AddrW-1:0];
        inp.act   = s_axis_tuser_i;
        inp.gtag  = s_axis_tdata_i[pahm_pkg::PtrW-1:pahm_pkg::AddrW];
      end else begin
        inp = stg_q[Pk];
        if (k == NRnd) begin
          // Key blocks done: inner chain continues, outer chain is parked.
          inp.run_a = pahm_pkg::md5_ff(pahm_pkg::Md5Iv, stg_q[Pk].run_a);
          inp.run_b = pahm_pkg::md5_ff(pahm_pkg::Md5Iv, stg_q[Pk].run_a);
          inp.hsave = pahm_pkg::md5_ff(pahm_pkg::Md5Iv, stg_q[Pk].run_b);
        end else if (k == 2 * NRnd) begin
          // Inner digest becomes the outer message; outer chain resumes.
          inp.msg   = pahm_pkg::md5_ff(stg_q[Pk].run_b, stg_q[Pk].run_a);
          inp.run_a = stg_q[Pk].hsave;
          inp.run_b = stg_q[Pk].hsave;
        end
      end
      stg_d[k] = inp;
      case (Ph)
        0: begin
          stg_d[k].run_a = pahm_pkg::md5_round(inp.run_a,
              pahm_pkg::key_word(inp.msg, Gi, pahm_pkg::IpadByte), Ri);
          stg_d[k].run_b = pahm_pkg::md5_round(inp.run_b,
              pahm_pkg::key_word(inp.msg, Gi, pahm_pkg::OpadByte), Ri);
        end
        1: begin
          stg_d[k].run_a = pahm_pkg::md5_round(inp.run_a,
              pahm_pkg::addr_word(inp.addr, Gi), Ri);
        end
        default: begin
          stg_d[k].run_a = pahm_pkg::md5_round(inp.run_a,
              pahm_pkg::dig_word(inp.msg, Gi), Ri);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NStg; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], s_axis_tvalid_i};
    end
  end

  // Final feed-forward gives the outer digest; its low half-word is the tag.
  always_comb begin
    tag = pahm_pkg::md5_ff(stg_q[NStg-1].run_b, stg_q[NStg-1].run_a)
          [pahm_pkg::TagW-1:0];
    if (stg_q[NStg-1].act) begin
      out_ptr_d  = {{pahm_pkg::TagW{1'b0}}, stg_q[NStg-1].addr};
      out_fail_d = (stg_q[NStg-1].gtag != tag);
    end else begin
      out_ptr_d  = {tag, stg_q[NStg-1].addr};
      out_fail_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[NStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ptr_q  <= out_ptr_d;
      out_fail_q <= out_fail_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_ptr_q;
  assign m_axis_tuser_o  = out_fail_q;

  // A stalled pipe keeps every valid bit where it is.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  // A word accepted at the input occupies the first stage next cycle.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> vld_q[0])
    else $error("accepted word missing from first stage");

  // The last stage's word lands in the output register when the pipe moves.
  a_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[NStg-1] |=> m_axis_tvalid_o)
    else $error("word lost between last stage and output");

  // Results for sign words never carry a failure flag.
  a_signok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld_q[NStg-1] && !stg_q[NStg-1].act |=> !m_axis_tuser_o)
    else $error("sign result flagged as failure");

endmodule
